/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define NFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/nfba_pkg.sv */
package nfba_pkg;

  localparam int unsigned POS_W     = 13;  // block positions and counts
  localparam int unsigned BASE_W    = 14;  // word base, holds position plus one word
  localparam int unsigned BN_W      = 12;  // block number fields
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA  = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL         = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE        = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

endpackage

/* rtl/core/next_fit_bitmap_block_allocator.sv */
// Allocate: the bitmap read port walks one word per cycle from word 0 up to min(total_blocks,
//   MAX_BLOCKS), then the result is registered; the walk stops early when a hit comes.
// Free: the walk stops at the word that holds block_number; an out-of-range free skips the walk.
// One request in flight; the next is taken once the result sits in the output register.
// Reset: bitmap cleared word by word with input stalled;
//   search pointer zero, both config registers 4096, output empty.
`include "assert_macros.svh"

module next_fit_bitmap_block_allocator
  import nfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS     = 4096,
  parameter int unsigned SCAN_WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [BN_W-1:0]      block_number_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BN_W-1:0]      granted_block_o,
  output logic [STAT_W-1:0]    status_o
);

  localparam int unsigned W      = SCAN_WORD_BITS;
  localparam int unsigned NWORDS = (MAX_BLOCKS + W - 1) / W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned OW     = (W > 1) ? $clog2(W) : 1;
  localparam logic [BASE_W-1:0] WSTEP     = BASE_W'(W);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(NWORDS - 1);
  localparam bit                CLAMP_ON  = (MAX_BLOCKS < 8192);
  localparam logic [POS_W-1:0]  MAX_LIM   = CLAMP_ON ? POS_W'(MAX_BLOCKS) : '1;

  // bits of the word at base that lie at or above position p
  function automatic logic [W-1:0] ge_mask(input logic [BASE_W-1:0] p,
                                           input logic [BASE_W-1:0] base);
    logic [BASE_W-1:0] d;
    logic [W-1:0]      m;
    d = p - base;
    if (p <= base) begin
      m = '1;
    end else if (d >= WSTEP) begin
      m = '0;
    end else begin
      m = {W{1'b1}} << d[OW-1:0];
    end
    return m;
  endfunction

  // bits of the word at base that lie below position p
  function automatic logic [W-1:0] lt_mask(input logic [BASE_W-1:0] p,
                                           input logic [BASE_W-1:0] base);
    logic [BASE_W-1:0] d;
    logic [W-1:0]      m;
    d = p - base;
    if (p <= base) begin
      m = '0;
    end else if (d >= WSTEP) begin
      m = '1;
    end else begin
      m = ~({W{1'b1}} << d[OW-1:0]);
    end
    return m;
  endfunction

  function automatic logic [OW-1:0] oh_idx(input logic [W-1:0] oh);
    logic [OW-1:0] idx;
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (oh[i]) idx = idx | OW'(i);
    end
    return idx;
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0]  total_q, data_q;
  logic [POS_W-1:0]  sstart_q, sstart_d;
  logic              req_q, req_d;
  logic [BN_W-1:0]   bn_q, bn_d;
  logic [POS_W-1:0]  p1_q, p1_d;

  logic [AW-1:0]     iss_addr_q, iss_addr_d;
  logic [BASE_W-1:0] iss_base_q, iss_base_d;
  logic              pend_vld_q, pend_vld_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic [BASE_W-1:0] pend_base_q, pend_base_d;
  logic [W-1:0]      rdata_q;

  logic              h2_vld_q, h2_vld_d;
  logic [POS_W-1:0]  h2_blk_q, h2_blk_d;
  logic [AW-1:0]     h2_addr_q, h2_addr_d;
  logic [W-1:0]      h2_data_q, h2_data_d;

  logic              fin_we_q, fin_we_d;
  logic [AW-1:0]     fin_addr_q, fin_addr_d;
  logic [W-1:0]      fin_data_q, fin_data_d;
  logic [BN_W-1:0]   res_blk_q, res_blk_d;
  logic [STAT_W-1:0] res_st_q, res_st_d;

  logic              out_vld_q, out_vld_d;
  logic [BN_W-1:0]   out_blk_q, out_blk_d;
  logic [STAT_W-1:0] out_st_q, out_st_d;

  logic [W-1:0]      bitmap_q [NWORDS];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [W-1:0]      mem_wd;

  logic [POS_W-1:0]  lim, nmeta;
  logic [BASE_W-1:0] lim_ext, bn_ext, fdiff, blk1, blk2;
  logic [W-1:0]      free_w, m1, m2, oh1, oh2, fbit;
  logic              in_word, out_pop, scan_end;

  assign lim     = (CLAMP_ON && (total_q > MAX_LIM)) ? MAX_LIM : total_q;
  assign nmeta   = (data_q > total_q) ? '0 : total_q - data_q;
  assign lim_ext = {1'b0, lim};
  assign bn_ext  = BASE_W'(bn_q);

  // per-word search on the registered read data
  assign free_w = ~rdata_q & lt_mask(lim_ext, pend_base_q);
  assign m1     = free_w & ge_mask({1'b0, p1_q}, pend_base_q);
  assign m2     = free_w & ge_mask({1'b0, nmeta}, pend_base_q);
  assign oh1    = m1 & (~m1 + W'(1));
  assign oh2    = m2 & (~m2 + W'(1));
  assign blk1   = pend_base_q + BASE_W'(oh_idx(oh1));
  assign blk2   = pend_base_q + BASE_W'(oh_idx(oh2));

  assign fdiff   = bn_ext - pend_base_q;
  assign in_word = (fdiff < WSTEP);
  assign fbit    = W'(1) << fdiff[OW-1:0];

  assign scan_end = !pend_vld_q && (iss_base_q >= lim_ext);
  assign out_pop  = out_vld_q && !out_stall_i;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_vld_q;
  assign granted_block_o = out_blk_q;
  assign status_o        = out_st_q;

  always_comb begin
    state_d     = state_q;
    sstart_d    = sstart_q;
    req_d       = req_q;
    bn_d        = bn_q;
    p1_d        = p1_q;
    iss_addr_d  = iss_addr_q;
    iss_base_d  = iss_base_q;
    pend_vld_d  = pend_vld_q;
    pend_addr_d = pend_addr_q;
    pend_base_d = pend_base_q;
    h2_vld_d    = h2_vld_q;
    h2_blk_d    = h2_blk_q;
    h2_addr_d   = h2_addr_q;
    h2_data_d   = h2_data_q;
    fin_we_d    = fin_we_q;
    fin_addr_d  = fin_addr_q;
    fin_data_d  = fin_data_q;
    res_blk_d   = res_blk_q;
    res_st_d    = res_st_q;
    out_vld_d   = out_vld_q;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    mem_we      = 1'b0;
    mem_wa      = fin_addr_q;
    mem_wd      = fin_data_q;

    if (out_pop) out_vld_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_wa     = iss_addr_q;
        mem_wd     = '0;
        iss_addr_d = iss_addr_q + AW'(1);
        if (iss_addr_q == LAST_ADDR) begin
          iss_addr_d = '0;
          state_d    = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          req_d      = req_type_i;
          bn_d       = block_number_i;
          p1_d       = (sstart_q == '0) ? nmeta : sstart_q;
          iss_addr_d = '0;
          iss_base_d = '0;
          pend_vld_d = 1'b0;
          h2_vld_d   = 1'b0;
          fin_we_d   = 1'b0;
          if (req_type_i == REQ_FREE && BASE_W'(block_number_i) >= lim_ext) begin
            res_blk_d = block_number_i;
            res_st_d  = ST_RANGE;
            state_d   = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read issue runs one word ahead of the compare
        if (iss_base_q < lim_ext) begin
          pend_vld_d  = 1'b1;
          pend_addr_d = iss_addr_q;
          pend_base_d = iss_base_q;
          iss_addr_d  = iss_addr_q + AW'(1);
          iss_base_d  = iss_base_q + WSTEP;
        end else begin
          pend_vld_d = 1'b0;
        end

        if (pend_vld_q) begin
          if (req_q == REQ_FREE) begin
            if (in_word) begin
              res_blk_d  = bn_q;
              fin_addr_d = pend_addr_q;
              fin_data_d = rdata_q & ~fbit;
              if ((rdata_q & fbit) == '0) begin
                res_st_d = ST_ALREADY_FREE;
                fin_we_d = 1'b0;
              end else begin
                res_st_d = ST_OK;
                fin_we_d = 1'b1;
              end
              state_d = S_FIN;
            end
          end else if (m1 != '0) begin
            fin_we_d   = 1'b1;
            fin_addr_d = pend_addr_q;
            fin_data_d = rdata_q | oh1;
            res_blk_d  = blk1[BN_W-1:0];
            res_st_d   = ST_OK;
            sstart_d   = blk1[POS_W-1:0];
            state_d    = S_FIN;
          end else if (!h2_vld_q && m2 != '0) begin
            // first free block at or above the metadata count, kept for the rescan case
            h2_vld_d  = 1'b1;
            h2_blk_d  = blk2[POS_W-1:0];
            h2_addr_d = pend_addr_q;
            h2_data_d = rdata_q | oh2;
          end
        end else if (scan_end) begin
          state_d = S_FIN;
          if (req_q == REQ_FREE) begin
            res_blk_d = bn_q;
            res_st_d  = ST_RANGE;
            fin_we_d  = 1'b0;
          end else if (h2_vld_q) begin
            fin_we_d   = 1'b1;
            fin_addr_d = h2_addr_q;
            fin_data_d = h2_data_q;
            res_blk_d  = h2_blk_q[BN_W-1:0];
            res_st_d   = ST_OK;
            sstart_d   = h2_blk_q;
          end else begin
            fin_we_d  = 1'b0;
            res_blk_d = '0;
            res_st_d  = ST_FULL;
            sstart_d  = nmeta;
          end
        end
      end

      S_FIN: begin
        // write may repeat while the output slot is busy; the data is the same
        mem_we = fin_we_q;
        if (!out_vld_q || out_pop) begin
          out_vld_d = 1'b1;
          out_blk_d = res_blk_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= CFG_RESET_VAL;
      data_q     <= CFG_RESET_VAL;
      sstart_q   <= '0;
      iss_addr_q <= '0;
      pend_vld_q <= 1'b0;
      h2_vld_q   <= 1'b0;
      fin_we_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL: total_q <= cfg_wdata_i;
          CFG_DATA:  data_q  <= cfg_wdata_i;
          default:   ;
        endcase
      end
      sstart_q   <= sstart_d;
      iss_addr_q <= iss_addr_d;
      pend_vld_q <= pend_vld_d;
      h2_vld_q   <= h2_vld_d;
      fin_we_q   <= fin_we_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    bn_q        <= bn_d;
    p1_q        <= p1_d;
    iss_base_q  <= iss_base_d;
    pend_addr_q <= pend_addr_d;
    pend_base_q <= pend_base_d;
    h2_blk_q    <= h2_blk_d;
    h2_addr_q   <= h2_addr_d;
    h2_data_q   <= h2_data_d;
    fin_addr_q  <= fin_addr_d;
    fin_data_q  <= fin_data_d;
    res_blk_q   <= res_blk_d;
    res_st_q    <= res_st_d;
    out_blk_q   <= out_blk_d;
    out_st_q    <= out_st_d;
  end

  // bitmap storage, one word per row
  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_q[mem_wa] <= mem_wd;
    rdata_q <= bitmap_q[iss_addr_q];
  end

  `NFBA_ASSERT(a_pend_in_range, (state_q == S_SCAN && pend_vld_q) |-> pend_base_q < lim_ext, "word compared beyond block limit")
  `NFBA_ASSERT(a_h2_in_range, (state_q == S_SCAN && h2_vld_q) |-> {1'b0, h2_blk_q} < lim_ext, "rescan candidate beyond block limit")
  `NFBA_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != S_IDLE, "transfer accepted but sequencer stayed idle")
  `NFBA_ASSERT(a_out_from_fin, $rose(out_valid_o) |-> $past(state_q == S_FIN), "result loaded outside finish step")

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nfba_pkg::*;

  localparam int unsigned DISK_BLOCKS   = 4096;
  localparam int unsigned SCAN_BITS     = 64;
  // worst allocation: one word per cycle over the whole map, plus pipeline
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned WATCHDOG_MAX  = 4000;

  typedef struct packed {
    logic [BN_W-1:0]   blk;
    logic [STAT_W-1:0] st;
  } grant_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = CFG_TOTAL;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i     = REQ_ALLOC;
  logic [BN_W-1:0]      block_number_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [BN_W-1:0]      granted_block_o;
  logic [STAT_W-1:0]    status_o;

  // allocator state as the testbench sees it
  bit [DISK_BLOCKS-1:0] block_used;
  logic [POS_W-1:0]     next_fit_ptr;
  logic [CFG_W-1:0]     geo_total;
  logic [CFG_W-1:0]     geo_data;

  grant_t      pending_grants[$];
  grant_t      head_grant;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned errors;
  int unsigned requests_sent;
  int unsigned geo_changes;
  int unsigned quiet_cycles;
  int unsigned status_count[4];

  next_fit_bitmap_block_allocator #(
    .MAX_BLOCKS    (DISK_BLOCKS),
    .SCAN_WORD_BITS(SCAN_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_block_o(granted_block_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned usable_blocks();
    return (geo_total > DISK_BLOCKS) ? DISK_BLOCKS : int'(geo_total);
  endfunction

  function automatic bit first_free(input int unsigned from, input int unsigned lim,
                                    output int unsigned hit);
    int unsigned i;
    hit = 0;
    for (i = from; i < lim; i++) begin
      if (!block_used[i]) begin
        hit = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t predict_grant(input logic req, input logic [BN_W-1:0] bn);
    grant_t      g;
    int unsigned lim;
    int unsigned meta;
    int unsigned from;
    int unsigned hit;
    bit          found;
    lim = usable_blocks();
    meta = 0;
    if (geo_data <= geo_total) meta = geo_total - geo_data;
    if (req == REQ_ALLOC) begin
      // a zero pointer counts as unset, so the search starts at the metadata count
      from = (next_fit_ptr == '0) ? meta : int'(next_fit_ptr);
      found = first_free(from, lim, hit);
      if (!found) begin
        next_fit_ptr = POS_W'(meta);
        found = first_free(meta, lim, hit);
      end
      if (found) begin
        block_used[hit] = 1'b1;
        next_fit_ptr = POS_W'(hit);
        g.blk = BN_W'(hit);
        g.st = ST_OK;
      end else begin
        g.blk = '0;
        g.st = ST_FULL;
      end
    end else begin
      g.blk = bn;
      if (bn >= lim) begin
        g.st = ST_RANGE;
      end else if (!block_used[bn]) begin
        g.st = ST_ALREADY_FREE;
      end else begin
        block_used[bn] = 1'b0;
        g.st = ST_OK;
      end
    end
    return g;
  endfunction

  // result side: random stall and in-order compare
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result: expected none, got block %0d status %0d",
                 $time, granted_block_o, status_o);
        errors++;
      end else begin
        head_grant = pending_grants.pop_front();
        status_count[head_grant.st]++;
        if (granted_block_o !== head_grant.blk) begin
          $display("%0t: granted_block mismatch: expected %0d, got %0d",
                   $time, head_grant.blk, granted_block_o);
          errors++;
        end
        if (status_o !== head_grant.st) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, head_grant.st, status_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("next_fit_bitmap_block_allocator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic req, input logic [BN_W-1:0] bn);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    block_number_i <= bn;
    do @(posedge clk_i); while (in_stall_o);
    pending_grants.push_back(predict_grant(req, bn));
    requests_sent++;
  endtask

  // hold off the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TOTAL;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    cfg_idx_i <= CFG_DATA;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    geo_total = total;
    geo_data = data;
    geo_changes++;
  endtask

  task automatic pick_geometry();
    logic [CFG_W-1:0] t;
    logic [CFG_W-1:0] d;
    case ($urandom_range(0, 9))
      0: begin
        t = CFG_W'(DISK_BLOCKS);
        d = CFG_W'($urandom_range(0, DISK_BLOCKS));
      end
      1: begin
        t = CFG_W'($urandom_range(0, 8191));
        d = CFG_W'($urandom_range(0, 8191));
      end
      2: begin
        t = '0;
        d = CFG_W'($urandom_range(0, 8191));
      end
      default: begin
        // small disks so that fills, wraps and full conditions come often
        t = CFG_W'($urandom_range(1, 96));
        d = CFG_W'($urandom_range(0, int'(t) + 8));
      end
    endcase
    set_geometry(t, d);
  endtask

  // mostly a block that is currently held, so frees actually release something
  function automatic logic [BN_W-1:0] pick_held(input int unsigned lim);
    int unsigned i;
    int unsigned cand;
    cand = 0;
    for (i = 0; i < 24; i++) begin
      cand = $urandom_range(0, lim - 1);
      if (block_used[cand]) return BN_W'(cand);
    end
    return BN_W'(cand);
  endfunction

  task automatic test_reset_geometry();
    // defaults: metadata count zero, pointer unset
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '1);
    send_req(REQ_FREE, 12'd0);
    send_req(REQ_FREE, 12'd0);
    send_req(REQ_FREE, 12'd4095);
    send_req(REQ_ALLOC, 12'd0);
  endtask

  task automatic test_fill_and_wrap();
    int unsigned k;
    set_geometry(13'd12, 13'd8);
    for (k = 0; k < 10; k++) send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 12'd12);
    send_req(REQ_FREE, 12'd4095);
    send_req(REQ_FREE, 12'd7);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 12'd2);
    send_req(REQ_FREE, 12'd0);
  endtask

  task automatic test_odd_geometry();
    // data above total, total above capacity, empty disk
    set_geometry(13'd16, 13'd20);
    send_req(REQ_ALLOC, '0);
    set_geometry(13'd8191, 13'd0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 12'd4095);
    set_geometry(13'd0, 13'd8191);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_FREE, 12'd0);
  endtask

  task automatic test_random_phase(input int unsigned gap, input int unsigned stall,
                                   input int unsigned items);
    int unsigned k;
    int unsigned roll;
    int unsigned lim;
    gap_pct = gap;
    stall_pct = stall;
    for (k = 0; k < items; k++) begin
      if (k % 48 == 0) pick_geometry();
      lim = usable_blocks();
      roll = $urandom_range(0, 99);
      if (roll < 52) begin
        send_req(REQ_ALLOC, BN_W'($urandom_range(0, 4095)));
      end else if (roll < 88 && lim != 0) begin
        send_req(REQ_FREE, pick_held(lim));
      end else begin
        send_req(REQ_FREE, BN_W'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    block_used = '0;
    next_fit_ptr = '0;
    geo_total = CFG_RESET_VAL;
    geo_data = CFG_RESET_VAL;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    requests_sent = 0;
    geo_changes = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_fill_and_wrap();
    test_odd_geometry();
    test_random_phase(0, 0, 192);
    test_random_phase(48, 0, 192);
    test_random_phase(0, 48, 192);
    test_random_phase(28, 28, 192);

    drain();
    $display("%0d requests over %0d disk geometries, with and without idle and stall",
             requests_sent, geo_changes);
    $display("results: %0d ok, %0d already free, %0d disk full, %0d out of range",
             status_count[ST_OK], status_count[ST_ALREADY_FREE],
             status_count[ST_FULL], status_count[ST_RANGE]);
    if (errors == 0) begin
      $display("next_fit_bitmap_block_allocator verification clean");
    end else begin
      $display("next_fit_bitmap_block_allocator verification failed");
    end
    $finish;
  end

endmodule

/* next_fit_bitmap_block_allocator.f */
+incdir+rtl/core
rtl/core/nfba_pkg.sv
rtl/core/next_fit_bitmap_block_allocator.sv
tb/sv/testbench.sv
